### rtl/jacobi_stencil_sweep_defines.svh
// assertion macros for the jacobi stencil sweep rtl
`ifndef JACOBI_STENCIL_SWEEP_DEFINES_SVH
`define JACOBI_STENCIL_SWEEP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define JSS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jss assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define JSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jss assertion failed");

`endif

### rtl/jss_pkg.sv
// shared types and constants for the jacobi stencil sweep
package jss_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int GRID_W_BITS = 11;
    localparam int GRID_H_BITS = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 8'd1;

    localparam int GRID_WIDTH_RESET  = 1024;
    localparam int GRID_HEIGHT_RESET = 1024;
    localparam int MIN_DIM           = 3;

    localparam int ROW_W       = 16;
    localparam int COL_W       = 10;
    localparam int OUT_VAL_W   = 32;
    localparam int OUT_TDATA_W = 128;

    // position and grid marks that travel with each interior point
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
        logic             clr;
    } jss_tag_t;

endpackage

### rtl/jss_ram.sv
// generic simple dual-port ram with registered read
module jss_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/jss_window.sv
// raster counters, line buffer and 5-point window gathering
module jss_window
    import jss_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [CFG_INDEX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    input  logic                         in_fire,
    input  logic signed [DATA_WIDTH-1:0] in_sample,
    output logic                         item_valid,
    output logic signed [DATA_WIDTH-1:0] item_up,
    output logic signed [DATA_WIDTH-1:0] item_down,
    output logic signed [DATA_WIDTH-1:0] item_left,
    output logic signed [DATA_WIDTH-1:0] item_right,
    output logic signed [DATA_WIDTH-1:0] item_center,
    output jss_tag_t                     item_tag
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int W_RESET = (GRID_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : GRID_WIDTH_RESET;

    logic [CW-1:0]          col_reg, col_next;
    logic [ROW_W-1:0]       row_reg, row_next;
    logic [WW-1:0]          w_reg, w_next;
    logic [GRID_H_BITS-1:0] h_reg, h_next;
    logic                   clr_pend_reg, clr_pend_next;
    logic [DATA_WIDTH-1:0]  left_reg;
    logic [2*DATA_WIDTH-1:0] cur_reg;
    logic [2*DATA_WIDTH-1:0] ram_rdata;

    logic [GRID_W_BITS-1:0] w_raw;
    logic [WW-1:0]          col_ext;
    logic [WW:0]            ahead;
    logic [WW:0]            ahead_addr;
    logic                   row_end;
    logic                   interior;
    logic                   grid_start;

    // each word holds {row above, two rows above} for one column
    jss_ram #(
        .WIDTH (2 * DATA_WIDTH),
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .clk   (clk),
        .we    (in_fire),
        .waddr (col_reg),
        .wdata ({in_sample, cur_reg[2*DATA_WIDTH-1:DATA_WIDTH]}),
        .re    (in_fire),
        .raddr (ahead_addr[CW-1:0]),
        .rdata (ram_rdata)
    );

    assign w_raw   = cfg_data[GRID_W_BITS-1:0];
    assign col_ext = WW'(col_reg);
    assign row_end = (col_ext + WW'(1)) == w_reg;
    assign grid_start = (col_reg == '0) && (row_reg == '0);
    assign interior = (row_reg >= ROW_W'(2)) && (col_reg != '0) && !row_end;

    // read two columns ahead so the right neighbour is ready at the next transaction
    always_comb
    begin
        ahead = (WW + 1)'(col_reg) + (WW + 1)'(2);
        if (ahead < (WW + 1)'(w_reg))
        begin
            ahead_addr = ahead;
        end
        else
        begin
            ahead_addr = ahead - (WW + 1)'(w_reg);
        end
    end

    always_comb
    begin
        w_next        = w_reg;
        h_next        = h_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        clr_pend_next = clr_pend_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_GRID_WIDTH:
                begin
                    if (w_raw < GRID_W_BITS'(MIN_DIM))
                    begin
                        w_next = WW'(MIN_DIM);
                    end
                    else if (32'(w_raw) > 32'(MAX_WIDTH))
                    begin
                        w_next = WW'(MAX_WIDTH);
                    end
                    else
                    begin
                        w_next = WW'(w_raw);
                    end
                    col_next = '0;
                    row_next = '0;
                end
                REG_GRID_HEIGHT:
                begin
                    if (cfg_data < GRID_H_BITS'(MIN_DIM))
                    begin
                        h_next = GRID_H_BITS'(MIN_DIM);
                    end
                    else
                    begin
                        h_next = cfg_data;
                    end
                    col_next = '0;
                    row_next = '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (in_fire)
        begin
            if (grid_start)
            begin
                clr_pend_next = 1'b1;
            end
            else if (interior)
            begin
                clr_pend_next = 1'b0;
            end
            if (row_end)
            begin
                col_next = '0;
                if (row_reg == h_reg - GRID_H_BITS'(1))
                begin
                    row_next = '0;
                end
                else
                begin
                    row_next = row_reg + ROW_W'(1);
                end
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg        <= WW'(W_RESET);
            h_reg        <= GRID_H_BITS'(GRID_HEIGHT_RESET);
            col_reg      <= '0;
            row_reg      <= '0;
            clr_pend_reg <= 1'b0;
        end
        else
        begin
            w_reg        <= w_next;
            h_reg        <= h_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            clr_pend_reg <= clr_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cur_reg  <= ram_rdata;
            left_reg <= cur_reg[2*DATA_WIDTH-1:DATA_WIDTH];
        end
    end

    assign item_valid  = in_fire && interior;
    assign item_center = cur_reg[2*DATA_WIDTH-1:DATA_WIDTH];
    assign item_up     = cur_reg[DATA_WIDTH-1:0];
    assign item_down   = in_sample;
    assign item_left   = left_reg;
    assign item_right  = ram_rdata[2*DATA_WIDTH-1:DATA_WIDTH];

    assign item_tag.row  = row_reg - ROW_W'(1);
    assign item_tag.col  = COL_W'(col_reg);
    assign item_tag.last = (row_reg == h_reg - GRID_H_BITS'(1))
                        && ((col_ext + WW'(2)) == w_reg);
    assign item_tag.clr  = clr_pend_reg;

endmodule

### rtl/jss_stencil.sv
// stencil arithmetic pipeline: mean, change, running maximum
`include "jacobi_stencil_sweep_defines.svh"
module jss_stencil
    import jss_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    output logic                         in_ready,
    input  logic                         item_valid,
    input  logic signed [DATA_WIDTH-1:0] item_up,
    input  logic signed [DATA_WIDTH-1:0] item_down,
    input  logic signed [DATA_WIDTH-1:0] item_left,
    input  logic signed [DATA_WIDTH-1:0] item_right,
    input  logic signed [DATA_WIDTH-1:0] item_center,
    input  jss_tag_t                     item_tag,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [OUT_VAL_W-1:0]         out_new_value,
    output logic [ROW_W-1:0]             out_row,
    output logic [COL_W-1:0]             out_col,
    output logic [OUT_VAL_W-1:0]         out_change,
    output logic [OUT_VAL_W-1:0]         out_max,
    output logic                         out_last
);

    // stage 1: window operands
    logic                         s1_valid_reg;
    logic signed [DATA_WIDTH-1:0] s1_up_reg, s1_down_reg, s1_left_reg, s1_right_reg;
    logic signed [DATA_WIDTH-1:0] s1_center_reg;
    jss_tag_t                     s1_tag_reg;
    // stage 2: new value
    logic                         s2_valid_reg;
    logic signed [DATA_WIDTH-1:0] s2_nv_reg, s2_center_reg;
    jss_tag_t                     s2_tag_reg;
    // stage 3: change
    logic                         s3_valid_reg;
    logic signed [DATA_WIDTH-1:0] s3_nv_reg;
    logic [DATA_WIDTH-1:0]        s3_d_reg;
    jss_tag_t                     s3_tag_reg;
    // result register
    logic                         out_valid_reg;
    logic [OUT_VAL_W-1:0]         out_nv_reg, out_change_reg, out_max_reg;
    jss_tag_t                     out_tag_reg;
    logic [DATA_WIDTH-1:0]        run_max_reg, run_max_next;

    logic                         out_stage_ready, s3_ready, s2_ready, s1_ready;
    logic                         out_load;
    logic signed [DATA_WIDTH+1:0] sum;
    logic signed [DATA_WIDTH:0]   diff;
    logic [DATA_WIDTH-1:0]        abs_diff;

    assign out_stage_ready = !out_valid_reg || out_ready;
    assign s3_ready = !s3_valid_reg || out_stage_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;
    assign out_load = s3_valid_reg && out_stage_ready;

    // floor of the mean: sum kept two bits wider, then drop the low two
    assign sum = (DATA_WIDTH + 2)'(s1_up_reg) + (DATA_WIDTH + 2)'(s1_down_reg)
               + (DATA_WIDTH + 2)'(s1_left_reg) + (DATA_WIDTH + 2)'(s1_right_reg);

    assign diff     = (DATA_WIDTH + 1)'(s2_nv_reg) - (DATA_WIDTH + 1)'(s2_center_reg);
    assign abs_diff = diff[DATA_WIDTH] ? DATA_WIDTH'(-diff) : DATA_WIDTH'(diff);

    always_comb
    begin
        if (s3_tag_reg.clr || (s3_d_reg > run_max_reg))
        begin
            run_max_next = s3_d_reg;
        end
        else
        begin
            run_max_next = run_max_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            run_max_reg   <= '0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= item_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_stage_ready)
            begin
                out_valid_reg <= s3_valid_reg;
            end
            if (out_load)
            begin
                run_max_reg <= run_max_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && item_valid)
        begin
            s1_up_reg     <= item_up;
            s1_down_reg   <= item_down;
            s1_left_reg   <= item_left;
            s1_right_reg  <= item_right;
            s1_center_reg <= item_center;
            s1_tag_reg    <= item_tag;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_nv_reg     <= sum[DATA_WIDTH+1:2];
            s2_center_reg <= s1_center_reg;
            s2_tag_reg    <= s1_tag_reg;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_nv_reg  <= s2_nv_reg;
            s3_d_reg   <= abs_diff;
            s3_tag_reg <= s2_tag_reg;
        end
        if (out_load)
        begin
            out_nv_reg     <= OUT_VAL_W'(s3_nv_reg);
            out_change_reg <= OUT_VAL_W'(s3_d_reg);
            out_max_reg    <= OUT_VAL_W'(run_max_next);
            out_tag_reg    <= s3_tag_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_new_value = out_nv_reg;
    assign out_row       = out_tag_reg.row;
    assign out_col       = out_tag_reg.col;
    assign out_change    = out_change_reg;
    assign out_max       = out_max_reg;
    assign out_last      = out_tag_reg.last;

    `JSS_ASSERT_NEXT(a_max_restart, out_load && s3_tag_reg.clr, run_max_reg == $past(s3_d_reg))
    `JSS_ASSERT_NEXT(a_max_covers, out_load, run_max_reg >= $past(s3_d_reg))
    `JSS_ASSERT_NEXT(a_max_holds, !out_load, run_max_reg == $past(run_max_reg))
    `JSS_ASSERT_NEXT(a_s3_stall, s3_valid_reg && !out_stage_ready, s3_valid_reg)

endmodule

### rtl/jacobi_stencil_sweep.sv
// top level of the streaming jacobi 5-point stencil sweep
//
//  channel   | direction | handshake                     | contents
//  s_axis    | in        | s_axis_tvalid / s_axis_tready | one grid sample, raster order
//  m_axis    | out       | m_axis_tvalid / m_axis_tready | one updated interior point
//  cfg       | in        | cfg_valid / cfg_ready         | grid_width (0), grid_height (1)
//
// one sample per cycle while s_axis_tready is high; an interior result is presented after
// the window taken at the sample below that point passes the four-register stencil pipeline;
// the line buffer is read two columns ahead, so its registered read already holds the right neighbour
// reset clears counters and pipeline valids; line buffer contents start undefined
// and are refilled by rows 0 and 1 of every grid, so no clearing pass is run
// a stalled m_axis backs up through the stage valids to s_axis_tready
module jacobi_stencil_sweep
    import jss_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // sample
    input  logic [((DATA_WIDTH + 7) / 8) * 8-1:0] s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // new_value, row_index, col_index, change, max_change, zero fill
    output logic [OUT_TDATA_W-1:0]               m_axis_tdata,
    output logic                                 m_axis_tlast,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [CFG_INDEX_W-1:0]               cfg_index,
    input  logic [CFG_DATA_W-1:0]                cfg_data
);

    localparam int FILL_W = OUT_TDATA_W - 3 * OUT_VAL_W - ROW_W - COL_W;

    logic                         in_fire;
    logic                         cfg_write;
    logic                         item_valid;
    logic signed [DATA_WIDTH-1:0] item_up, item_down, item_left, item_right, item_center;
    jss_tag_t                     item_tag;
    logic [OUT_VAL_W-1:0]         out_new_value, out_change, out_max;
    logic [ROW_W-1:0]             out_row;
    logic [COL_W-1:0]             out_col;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign in_fire   = s_axis_tvalid && s_axis_tready;

    jss_window #(
        .MAX_WIDTH  (MAX_WIDTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_fire     (in_fire),
        .in_sample   (s_axis_tdata[DATA_WIDTH-1:0]),
        .item_valid  (item_valid),
        .item_up     (item_up),
        .item_down   (item_down),
        .item_left   (item_left),
        .item_right  (item_right),
        .item_center (item_center),
        .item_tag    (item_tag)
    );

    jss_stencil #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_stencil (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ready      (s_axis_tready),
        .item_valid    (item_valid),
        .item_up       (item_up),
        .item_down     (item_down),
        .item_left     (item_left),
        .item_right    (item_right),
        .item_center   (item_center),
        .item_tag      (item_tag),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_new_value (out_new_value),
        .out_row       (out_row),
        .out_col       (out_col),
        .out_change    (out_change),
        .out_max       (out_max),
        .out_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {{FILL_W{1'b0}}, out_max, out_change, out_col, out_row, out_new_value};

endmodule

### tb/sv/jss_checker.sv
`timescale 1ns / 100ps
// scoreboard for the stencil sweep: predicts every interior point and compares m_axis
module jss_checker
    import jss_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [31:0]            s_axis_tdata,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   m_axis_tlast,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     fail_count,
    output int                     outstanding
);

    // bit offsets of the result fields in m_axis_tdata
    localparam int NEW_LSB = 0;
    localparam int ROW_LSB = 32;
    localparam int COL_LSB = 48;
    localparam int CHG_LSB = 58;
    localparam int MAX_LSB = 90;

    typedef struct packed {
        logic [OUT_VAL_W-1:0] new_value;
        logic [ROW_W-1:0]     row_index;
        logic [COL_W-1:0]     col_index;
        logic [OUT_VAL_W-1:0] change;
        logic [OUT_VAL_W-1:0] max_change;
        logic                 last;
    } point_t;

    point_t                 pending_points[$];
    logic [31:0]            older_row [MAX_WIDTH];
    logic [31:0]            prev_row [MAX_WIDTH];
    logic [31:0]            left_delay [2];
    logic [GRID_W_BITS-1:0] width_reg;
    logic [GRID_H_BITS-1:0] height_reg;
    int unsigned            col_pos;
    int unsigned            row_pos;
    logic [31:0]            peak_change;
    int                     errors;

    task automatic advance_stencil(input logic [31:0] incoming);
        int unsigned        w;
        int unsigned        h;
        int unsigned        c;
        int unsigned        r;
        logic signed [31:0] down;
        logic signed [31:0] center;
        logic signed [31:0] up;
        logic signed [31:0] left;
        logic signed [31:0] right;
        logic signed [31:0] updated;
        logic signed [33:0] total;
        logic signed [32:0] delta;
        logic [31:0]        change;
        point_t             pt;
        w = (width_reg < MIN_DIM) ? MIN_DIM : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
        h = (height_reg < MIN_DIM) ? MIN_DIM : height_reg;
        c = (col_pos >= w) ? 0 : col_pos;
        r = (row_pos >= h) ? 0 : row_pos;
        if (c == 0 && r == 0)
            peak_change = '0;
        down   = incoming;
        center = prev_row[c];
        up     = older_row[c];
        left   = left_delay[0];
        right  = (c + 1 < w) ? prev_row[c + 1] : '0;
        if (r >= 2 && c >= 1 && c + 1 < w)
        begin
            // 34-bit sum cannot overflow; arithmetic shift gives the floor of the mean
            total   = up + down + left + right;
            total   = total >>> 2;
            updated = total[31:0];
            delta   = updated - center;
            if (delta < 0)
                delta = -delta;
            change = delta[31:0];
            if (change > peak_change)
                peak_change = change;
            pt.new_value  = updated;
            pt.row_index  = ROW_W'(r - 1);
            pt.col_index  = COL_W'(c);
            pt.change     = change;
            pt.max_change = peak_change;
            pt.last       = (r == h - 1 && c == w - 2);
            pending_points.push_back(pt);
        end
        older_row[c]  = center;
        prev_row[c]   = down;
        left_delay[1] = left_delay[0];
        left_delay[0] = center;
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h)
                r = 0;
        end
        col_pos = c;
        row_pos = r;
    endtask

    function automatic bit field_bad(string field, logic [31:0] want, logic [31:0] got);
        if (want === got)
            return 1'b0;
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        point_t want;
        bit     bad;
        if (!rst_n)
        begin
            pending_points.delete();
            for (int i = 0; i < MAX_WIDTH; i++)
            begin
                older_row[i] = '0;
                prev_row[i]  = '0;
            end
            left_delay[0] = '0;
            left_delay[1] = '0;
            width_reg     = GRID_W_BITS'(GRID_WIDTH_RESET);
            height_reg    = GRID_H_BITS'(GRID_HEIGHT_RESET);
            col_pos       = 0;
            row_pos       = 0;
            peak_change   = '0;
            errors        = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                // a known register restarts the grid, other indexes leave it running
                if (cfg_index == REG_GRID_WIDTH)
                begin
                    width_reg = cfg_data[GRID_W_BITS-1:0];
                    col_pos   = 0;
                    row_pos   = 0;
                end
                else if (cfg_index == REG_GRID_HEIGHT)
                begin
                    height_reg = cfg_data[GRID_H_BITS-1:0];
                    col_pos    = 0;
                    row_pos    = 0;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                advance_stencil(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_points.size() == 0)
                begin
                    $error("result transaction with no interior point waiting");
                    errors++;
                end
                else
                begin
                    want = pending_points.pop_front();
                    bad  = 1'b0;
                    bad |= field_bad("new_value", want.new_value,
                                     m_axis_tdata[NEW_LSB +: OUT_VAL_W]);
                    bad |= field_bad("row_index", want.row_index,
                                     m_axis_tdata[ROW_LSB +: ROW_W]);
                    bad |= field_bad("col_index", want.col_index,
                                     m_axis_tdata[COL_LSB +: COL_W]);
                    bad |= field_bad("change", want.change,
                                     m_axis_tdata[CHG_LSB +: OUT_VAL_W]);
                    bad |= field_bad("max_change", want.max_change,
                                     m_axis_tdata[MAX_LSB +: OUT_VAL_W]);
                    bad |= field_bad("last", want.last, m_axis_tlast);
                    if (bad)
                        errors++;
                end
            end
        end
        fail_count  <= errors;
        outstanding <= pending_points.size();
    end

endmodule

### tb/sv/jacobi_stencil_sweep_tb.sv
`timescale 1ns / 100ps
// testbench top for the stencil sweep: clock, reset, stimulus, backpressure and verdict
module jacobi_stencil_sweep_tb;
    import jss_pkg::*;

    localparam int MAX_WIDTH    = 1024;
    localparam int DATA_WIDTH   = 32;
    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_CYCLES = 12;
    localparam int LONG_HOLD    = 300;
    localparam int RANDOM_ITEMS = 300;
    localparam int QUIET_ITEMS  = 100;
    localparam int TIMEOUT_NS   = 10_000_000;

    typedef enum int unsigned {
        FILL_FULL,
        FILL_NEAR_ZERO,
        FILL_EXTREME,
        FILL_MIXED
    } fill_mode_t;

    // three 3x3 grids: overflow toward the top, toward the bottom, and a negative floor
    localparam logic [31:0] CORNER_GRIDS [27] = '{
        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
        32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
        32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
        32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
        32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
        32'h1234_5678, 32'hFFFF_FFFF, 32'h0000_0000,
        32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
        32'h5555_5555, 32'h0000_0000, 32'hAAAA_AAAA
    };

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [31:0]            s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;
    int                     fail_count;
    int                     outstanding;
    bit                     idle_en       = 1'b1;
    bit                     hold_req      = 1'b0;

    jacobi_stencil_sweep #(
        .MAX_WIDTH  (MAX_WIDTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    jss_checker #(
        .MAX_WIDTH (MAX_WIDTH)
    ) i_stencil_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] pick_value(fill_mode_t mode);
        int unsigned kind;
        kind = (mode == FILL_MIXED) ? $urandom_range(FILL_FULL, FILL_EXTREME) : mode;
        case (kind)
            FILL_FULL:      return $urandom();
            FILL_NEAR_ZERO: return $urandom_range(0, 4000) - 32'd2000;
            default:
            begin
                case ($urandom_range(0, 4))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    3:       return 32'hFFFF_FFFF;
                    default: return $urandom();
                endcase
            end
        endcase
    endfunction

    task automatic push_sample(input logic [31:0] value);
        if (idle_en && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic stream_values(input int count, input fill_mode_t mode);
        for (int i = 0; i < count; i++)
            push_sample(pick_value(mode));
    endtask

    // stop offering, let every expected point come out, then give the pipeline time to empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_grid(input logic [15:0] width_word, input logic [15:0] height_word);
        cfg_valid <= 1'b1;
        cfg_index <= REG_GRID_WIDTH;
        cfg_data  <= width_word;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= REG_GRID_HEIGHT;
        cfg_data  <= height_word;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic poke_unused(input logic [7:0] index, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // result side: random stalls, one long hold on request, none in the quiet tail
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else if (idle_en && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int unsigned raw_w;
        int unsigned raw_h;
        int unsigned w;
        int unsigned h;
        int unsigned count;
        int          random_items;
        fill_mode_t  mode;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_grid(16'd3, 16'd3);
        foreach (CORNER_GRIDS[i])
            push_sample(CORNER_GRIDS[i]);
        settle();

        // sizes below the minimum run as 3x3
        set_grid(16'd0, 16'd1);
        stream_values(4 * 9, FILL_MIXED);
        settle();

        // only the low 11 bits of the width count: 5 columns
        set_grid(16'hF805, 16'd4);
        stream_values(7, FILL_MIXED);
        settle();
        poke_unused(8'hFF, 16'hFFFF);
        stream_values(2 * 20 - 7, FILL_MIXED);
        settle();

        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            if (random_items == 0)
            begin
                raw_w = 10;
                raw_h = 8;
                count = 3 * 10 * 8;
            end
            else
            begin
                raw_w = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
                raw_h = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
                w     = (raw_w < MIN_DIM) ? MIN_DIM : raw_w;
                h     = (raw_h < MIN_DIM) ? MIN_DIM : raw_h;
                count = w * h * $urandom_range(1, 3);
                // some runs stop partway through a grid
                if ($urandom_range(0, 4) == 0)
                    count += $urandom_range(1, w * h - 1);
            end
            if (random_items >= RANDOM_ITEMS - QUIET_ITEMS)
                idle_en = 1'b0;
            mode = fill_mode_t'($urandom_range(FILL_FULL, FILL_MIXED));
            set_grid(16'(raw_w), 16'(raw_h));
            if (random_items == 0)
                hold_req = 1'b1;
            stream_values(count, mode);
            random_items += count;
            settle();
            if ($urandom_range(0, 5) == 0)
                poke_unused(8'($urandom_range(2, 255)), 16'($urandom()));
        end

        if (fail_count == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
